// ===== rtl/core/edm_pkg.sv =====
// Shared types and codes for the edit distance matcher.
// No dependencies; imported by edm_cell and edit_distance_matcher.
package edm_pkg;

   // Request kinds carried on req_tuser
   localparam logic [1:0] FUNC_PAT = 2'd0;  // append pattern byte
   localparam logic [1:0] FUNC_TXT = 2'd1;  // text byte, advances the column
   localparam logic [1:0] FUNC_END = 2'd2;  // end of pair, emits result

   localparam int CH_W   = 8;
   localparam int DIST_W = 6;
   localparam int THR_W  = 6;

   // Wavefront token handed from cell to cell
   typedef struct packed {
      logic            valid;
      logic [CH_W-1:0] ch;
   } tok_type;

endpackage

// ===== rtl/core/edm_cell.sv =====
// One row of the edit distance column: pattern byte, DP entry, wavefront regs.
// Depends on edm_pkg.
module edm_cell
   import edm_pkg::*;
#(
   parameter int DW = 6
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  logic [CH_W-1:0] load_ch,
   input  logic [DW-1:0]   load_dp,
   input  logic            clear,
   input  tok_type         tok_i,
   input  logic [DW-1:0]   up_i,
   input  logic [DW-1:0]   diag_i,
   output tok_type         tok_o,
   output logic [DW-1:0]   up_o,
   output logic [DW-1:0]   diag_o,
   output logic [DW-1:0]   dp_o,
   output logic            active_o
);

   logic [CH_W-1:0] pchar_ff;
   logic [DW-1:0]   dp_ff, dp_in;
   logic            active_ff;
   tok_type         tok_ff;
   logic [DW-1:0]   up_ff, diag_ff;
   logic [DW-1:0]   min_a, min_b;
   logic            step;

   assign step = tok_i.valid && active_ff;

   always_comb begin
      min_a = (up_i < diag_i) ? up_i : diag_i;
      min_b = (min_a < dp_ff) ? min_a : dp_ff;
      if (pchar_ff == tok_i.ch) begin
         dp_in = diag_i;
      end else begin
         dp_in = min_b + DW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         tok_ff.valid <= 1'b0;
         dp_ff        <= '0;
      end else begin
         tok_ff.valid <= step;
         if (load) begin
            active_ff <= 1'b1;
            dp_ff     <= load_dp;
         end else if (clear) begin
            active_ff <= 1'b0;
         end else if (step) begin
            dp_ff <= dp_in;
         end
      end
      if (load) begin
         pchar_ff <= load_ch;
      end
      tok_ff.ch <= tok_i.ch;
      up_ff     <= dp_in;
      diag_ff   <= dp_ff;
   end

   assign tok_o    = tok_ff;
   assign up_o     = up_ff;
   assign diag_o   = diag_ff;
   assign dp_o     = dp_ff;
   assign active_o = active_ff;

endmodule

// ===== rtl/core/edit_distance_matcher.sv =====
// Levenshtein distance matcher: boundary row, cell chain, result register.
// Depends on edm_pkg and edm_cell.
//
// Usage:
//   req_* : item stream. req_tuser = kind (pattern byte, text byte, end of
//           pair), req_tdata = the byte. Pattern bytes fill cells 1..len in
//           order; text bytes enter the chain as a wavefront, one per cycle.
//   rsp_* : one transfer per end-of-pair item: distance, match flag and
//           overflow flag, held in an output register.
//   csr_* : threshold write, taken at any time the block is idle.
// Throughput: pattern and text bytes are taken every cycle. An end item waits
//   until the last text byte has crossed all active cells.
// Latency: the result is presented the cycle after the end item transfers.
// Stall: while a result is not taken, a further end item is held off;
//   pattern and text bytes still flow.
// Reset: clears all lengths, flags and cells; threshold returns to 3.
module edit_distance_matcher
   import edm_pkg::*;
#(
   parameter int MAX_LEN = 32
) (
   input  logic             clock,
   input  logic             reset,
   // slave side
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] ch
   input  logic [1:0]       req_tuser,   // [1:0] func
   // master side
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // [5:0] distance, [6] is_match, [7] overflow
   // threshold register
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [THR_W-1:0] csr_data
);

   // DP values never exceed MAX_LEN
   localparam int DW = $clog2(MAX_LEN + 1);
   localparam int XW = (DW > DIST_W) ? DW : DIST_W;

   logic [THR_W-1:0] threshold_ff;
   logic [DW-1:0]    pat_len_ff, text_len_ff, dp0_ff, drain_ff;
   logic             ovf_ff;
   logic             rsp_valid_ff;
   logic [7:0]       rsp_data_ff;

   // row 0 outputs feeding the first cell
   tok_type          tok0_ff;
   logic [DW-1:0]    up0_ff, dg0_ff;

   tok_type          tok   [0:MAX_LEN];
   logic [DW-1:0]    up    [0:MAX_LEN];
   logic [DW-1:0]    dg    [0:MAX_LEN];
   logic [DW-1:0]    dp    [1:MAX_LEN];
   logic [MAX_LEN:1] active;

   logic             xfer, end_ok;
   logic             is_pat, is_txt, is_end;
   logic             pat_ok, txt_ok;
   logic [DW-1:0]    tail_dp;
   logic [XW-1:0]    dist_x;

   // ---------------------------------------------------------------- handshake
   assign end_ok     = (drain_ff == '0) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (req_tuser != FUNC_END) || end_ok;
   assign xfer       = req_tvalid && req_tready;
   assign is_pat     = xfer && (req_tuser == FUNC_PAT);
   assign is_txt     = xfer && (req_tuser == FUNC_TXT);
   assign is_end     = xfer && (req_tuser == FUNC_END);
   // pattern bytes after text are dropped silently
   assign pat_ok     = is_pat && (text_len_ff == '0) && (pat_len_ff != DW'(MAX_LEN));
   assign txt_ok     = is_txt && (text_len_ff != DW'(MAX_LEN));
   assign csr_ready  = 1'b1;

   // ------------------------------------------------------- boundary (row 0)
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= THR_W'(3);
         pat_len_ff    <= '0;
         text_len_ff   <= '0;
         dp0_ff        <= '0;
         drain_ff      <= '0;
         ovf_ff        <= 1'b0;
         tok0_ff.valid <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            threshold_ff <= csr_data;
         end
         tok0_ff.valid <= txt_ok;
         if (pat_ok) begin
            pat_len_ff <= pat_len_ff + DW'(1);
         end
         if ((is_pat && (text_len_ff == '0) && !pat_ok) || (is_txt && !txt_ok)) begin
            ovf_ff <= 1'b1;
         end
         if (txt_ok) begin
            text_len_ff <= text_len_ff + DW'(1);
            dp0_ff      <= text_len_ff + DW'(1);
            drain_ff    <= pat_len_ff;   // counts down while the wavefront travels to the tail
         end else if (drain_ff != '0) begin
            drain_ff <= drain_ff - DW'(1);
         end
         if (is_end) begin
            pat_len_ff   <= '0;
            text_len_ff  <= '0;
            dp0_ff       <= '0;
            ovf_ff       <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      tok0_ff.ch <= req_tdata;
      up0_ff     <= text_len_ff + DW'(1);
      dg0_ff     <= dp0_ff;
      if (is_end) begin
         rsp_data_ff <= {ovf_ff,
                         (dist_x <= XW'(threshold_ff)),
                         (dist_x > XW'(63)) ? 6'd63 : dist_x[DIST_W-1:0]};
      end
   end

   assign tok[0] = tok0_ff;
   assign up[0]  = up0_ff;
   assign dg[0]  = dg0_ff;

   // --------------------------------------------------------------- cell chain
   for (genvar g = 1; g <= MAX_LEN; g++) begin : g_cell
      edm_cell #(
         .DW (DW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .load     (pat_ok && (pat_len_ff == DW'(g - 1))),
         .load_ch  (req_tdata),
         .load_dp  (DW'(g)),
         .clear    (is_end),
         .tok_i    (tok[g-1]),
         .up_i     (up[g-1]),
         .diag_i   (dg[g-1]),
         .tok_o    (tok[g]),
         .up_o     (up[g]),
         .diag_o   (dg[g]),
         .dp_o     (dp[g]),
         .active_o (active[g])
      );
   end

   // tail entry: last active cell, or row 0 for an empty pattern
   always_comb begin
      tail_dp = active[1] ? '0 : dp0_ff;
      for (int i = 1; i <= MAX_LEN; i++) begin
         if (active[i] && ((i == MAX_LEN) || !active[(i < MAX_LEN) ? i + 1 : i])) begin
            tail_dp = tail_dp | dp[i];
         end
      end
      dist_x = XW'(tail_dp);
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // --------------------------------------------------------------- assertions
   a_rsp_from_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && (req_tuser == FUNC_END)))
      else $error("result raised without an end-of-pair transfer");

   a_no_end_in_flight: assert property (@(posedge clock) disable iff (reset)
      (drain_ff != '0) |-> !(req_tvalid && req_tready && (req_tuser == FUNC_END)))
      else $error("end of pair taken while wavefront in flight");

   a_cells_match_len: assert property (@(posedge clock) disable iff (reset)
      $countones(active) == int'(pat_len_ff))
      else $error("active cell count differs from pattern length");

   a_text_bounded: assert property (@(posedge clock) disable iff (reset)
      int'(text_len_ff) <= MAX_LEN)
      else $error("text length beyond limit");

endmodule
